>>> src/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// shared constants and types of the spectral delay line multiply-accumulate
// ----------------------------------------------------------------------------
package sdl_pkg;

  localparam int PARTITIONS = 8;
  localparam int BLOCK_SIZE = 64;
  localparam int NBINS      = BLOCK_SIZE + 1;

  localparam int PART_W = 3;
  localparam int BIN_W  = 7;
  localparam int VAL_W  = 24;
  localparam int PROD_W = 2 * VAL_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = 56;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 120;

  // sequencer counter covers the sweep and the accumulate wait
  localparam int CNT_MAX = (NBINS > PARTITIONS + 3) ? NBINS : PARTITIONS + 3;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] im;
    logic signed [VAL_W-1:0] re;
  } cplx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] im;
    logic signed [SUM_W-1:0] re;
  } acc_t;

  typedef struct packed {
    logic [BIN_W-1:0] rd_addr;
    logic [BIN_W-1:0] wr_addr;
    cplx_t            coef_wdata;
  } cell_ctrl_t;

endpackage

>>> src/sdl_cell.sv
// ----------------------------------------------------------------------------
// sdl_cell
// one partition cell: spectrum and coefficient bins, complex product and
// one step of the accumulate chain
// ----------------------------------------------------------------------------
module sdl_cell (
  input  logic                clk_i,
  input  sdl_pkg::cell_ctrl_t ctrl_i,
  input  logic                spec_we_i,
  input  sdl_pkg::cplx_t      spec_wdata_i,
  input  logic                coef_we_i,
  input  sdl_pkg::acc_t       acc_i,
  output sdl_pkg::cplx_t      spec_o,
  output sdl_pkg::acc_t       acc_o
);

  sdl_pkg::cplx_t spec_mem [sdl_pkg::NBINS];
  sdl_pkg::cplx_t coef_mem [sdl_pkg::NBINS];

  sdl_pkg::cplx_t spec_q;
  sdl_pkg::cplx_t coef_q;

  logic signed [sdl_pkg::PROD_W-1:0] pac_q, pbd_q, pad_q, pbc_q;
  logic signed [sdl_pkg::PROD_W-1:0] pac_d, pbd_d, pad_d, pbc_d;
  logic signed [sdl_pkg::TERM_W-1:0] term_re_q, term_im_q;
  sdl_pkg::acc_t                     acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (spec_we_i) begin
      spec_mem[ctrl_i.wr_addr] <= spec_wdata_i;
    end
    spec_q <= spec_mem[ctrl_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_mem[ctrl_i.wr_addr] <= ctrl_i.coef_wdata;
    end
    coef_q <= coef_mem[ctrl_i.rd_addr];
  end

  assign pac_d = sdl_pkg::PROD_W'(spec_q.re) * sdl_pkg::PROD_W'(coef_q.re);
  assign pbd_d = sdl_pkg::PROD_W'(spec_q.im) * sdl_pkg::PROD_W'(coef_q.im);
  assign pad_d = sdl_pkg::PROD_W'(spec_q.re) * sdl_pkg::PROD_W'(coef_q.im);
  assign pbc_d = sdl_pkg::PROD_W'(spec_q.im) * sdl_pkg::PROD_W'(coef_q.re);

  always_comb begin
    acc_d.re = acc_i.re + sdl_pkg::SUM_W'(term_re_q);
    acc_d.im = acc_i.im + sdl_pkg::SUM_W'(term_im_q);
  end

  always_ff @(posedge clk_i) begin
    pac_q     <= pac_d;
    pbd_q     <= pbd_d;
    pad_q     <= pad_d;
    pbc_q     <= pbc_d;
    term_re_q <= sdl_pkg::TERM_W'(pac_q) - sdl_pkg::TERM_W'(pbd_q);
    term_im_q <= sdl_pkg::TERM_W'(pad_q) + sdl_pkg::TERM_W'(pbc_q);
    acc_q     <= acc_d;
  end

  assign spec_o = spec_q;
  assign acc_o  = acc_q;

endmodule

>>> src/spectral_delay_line_mac.sv
// ----------------------------------------------------------------------------
// spectral_delay_line_mac
// frequency-domain delay line with complex multiply-accumulate over partitions
// ----------------------------------------------------------------------------
// A row of PARTITIONS cells; cell p holds the coefficient bins of partition p
// and the spectrum of the block that is p blocks old. A coefficient load is
// written into its cell while the block stays idle. A spectrum bin is written
// into cell 0, read in all cells at once, multiplied, and the partial sums run
// down the row through a register in each cell; the result enters the output
// register once the row is summed and that register is free, and only then is
// the next item taken. The last bin of a block rotates every spectrum one cell
// down the row, one bin a cycle, the oldest going to cell 0. After reset all
// spectra are cleared, during which no item is taken.
module spectral_delay_line_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // partition, bin_index, value_real, value_imag, zero pad
  input  logic [sdl_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // command
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_bin, sum_real, sum_imag, zero pad
  output logic [sdl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // block_done
  output logic                               m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_SWEEP
  } state_e;

  state_e                      state_q, state_d;
  logic [sdl_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [sdl_pkg::BIN_W-1:0]   bin_q, bin_d;
  logic                        m_valid_q, m_valid_d;
  logic [sdl_pkg::BIN_W-1:0]   out_bin_q, out_bin_d;
  logic [sdl_pkg::SUM_W-1:0]   sum_re_q, sum_re_d;
  logic [sdl_pkg::SUM_W-1:0]   sum_im_q, sum_im_d;
  logic                        last_q, last_d;

  logic [sdl_pkg::PART_W-1:0]  in_part;
  logic [sdl_pkg::BIN_W-1:0]   in_bin;
  sdl_pkg::cplx_t              in_val;
  logic                        in_fire, in_ok, spec_in, coef_in, out_load;

  sdl_pkg::cell_ctrl_t         ctrl;
  logic [sdl_pkg::PARTITIONS-1:0] spec_we, coef_we;
  sdl_pkg::cplx_t              spec_wdata [sdl_pkg::PARTITIONS];
  sdl_pkg::cplx_t              spec_rd    [sdl_pkg::PARTITIONS];
  sdl_pkg::acc_t               acc_chain  [sdl_pkg::PARTITIONS+1];

  assign in_part = s_axis_tdata_i[sdl_pkg::PART_W-1:0];
  assign in_bin  = s_axis_tdata_i[sdl_pkg::PART_W +: sdl_pkg::BIN_W];
  assign in_val.re = s_axis_tdata_i[sdl_pkg::PART_W+sdl_pkg::BIN_W +: sdl_pkg::VAL_W];
  assign in_val.im = s_axis_tdata_i[sdl_pkg::PART_W+sdl_pkg::BIN_W+sdl_pkg::VAL_W +:
                                    sdl_pkg::VAL_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_ok   = (int'(in_bin) <= sdl_pkg::BLOCK_SIZE);
  assign spec_in = in_fire && in_ok && s_axis_tuser_i;
  assign coef_in = in_fire && in_ok && !s_axis_tuser_i;

  assign out_load = (state_q == ST_RUN) &&
                    (cnt_q == sdl_pkg::CNT_W'(sdl_pkg::PARTITIONS + 3)) &&
                    (!m_valid_q || m_axis_tready_i);

  // cell control
  always_comb begin
    ctrl.coef_wdata = in_val;
    ctrl.rd_addr    = bin_q;
    ctrl.wr_addr    = in_bin;
    case (state_q)
      ST_CLEAR: begin
        ctrl.wr_addr = cnt_q[sdl_pkg::BIN_W-1:0];
      end
      ST_SWEEP: begin
        ctrl.rd_addr = (cnt_q < sdl_pkg::CNT_W'(sdl_pkg::NBINS)) ?
                       cnt_q[sdl_pkg::BIN_W-1:0] : '0;
        ctrl.wr_addr = sdl_pkg::BIN_W'(cnt_q - 1'b1);
      end
      default: begin
        ctrl.wr_addr = in_bin;
      end
    endcase
  end

  assign acc_chain[0] = '0;

  for (genvar p = 0; p < sdl_pkg::PARTITIONS; p++) begin : g_cell
    localparam int PREV = (p + sdl_pkg::PARTITIONS - 1) % sdl_pkg::PARTITIONS;

    always_comb begin
      spec_we[p] = (state_q == ST_CLEAR) ||
                   ((state_q == ST_SWEEP) && (cnt_q != '0)) ||
                   ((p == 0) && spec_in);
      coef_we[p] = coef_in && (int'(in_part) == p);
      if (state_q == ST_CLEAR) begin
        spec_wdata[p] = '0;
      end else if (state_q == ST_SWEEP) begin
        spec_wdata[p] = spec_rd[PREV];
      end else begin
        spec_wdata[p] = in_val;
      end
    end

    sdl_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .spec_we_i    (spec_we[p]),
      .spec_wdata_i (spec_wdata[p]),
      .coef_we_i    (coef_we[p]),
      .acc_i        (acc_chain[p]),
      .spec_o       (spec_rd[p]),
      .acc_o        (acc_chain[p+1])
    );
  end

  // sequencer and output register
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bin_d     = bin_q;
    m_valid_d = m_valid_q;
    out_bin_d = out_bin_q;
    sum_re_d  = sum_re_q;
    sum_im_d  = sum_im_q;
    last_d    = last_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sdl_pkg::CNT_W'(sdl_pkg::NBINS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        if (spec_in) begin
          state_d = ST_RUN;
          cnt_d   = '0;
          bin_d   = in_bin;
        end
      end
      ST_RUN: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          out_bin_d = bin_q;
          sum_re_d  = acc_chain[sdl_pkg::PARTITIONS].re;
          sum_im_d  = acc_chain[sdl_pkg::PARTITIONS].im;
          last_d    = (bin_q == sdl_pkg::BIN_W'(sdl_pkg::BLOCK_SIZE));
          cnt_d     = '0;
          state_d   = (bin_q == sdl_pkg::BIN_W'(sdl_pkg::BLOCK_SIZE)) ? ST_SWEEP : ST_IDLE;
        end else if (cnt_q != sdl_pkg::CNT_W'(sdl_pkg::PARTITIONS + 3)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sdl_pkg::CNT_W'(sdl_pkg::NBINS)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      bin_q     <= '0;
      m_valid_q <= 1'b0;
      out_bin_q <= '0;
      sum_re_q  <= '0;
      sum_im_q  <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      bin_q     <= bin_d;
      m_valid_q <= m_valid_d;
      out_bin_q <= out_bin_d;
      sum_re_q  <= sum_re_d;
      sum_im_q  <= sum_im_d;
      last_q    <= last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {{(sdl_pkg::OUT_TDATA_W - sdl_pkg::BIN_W - 2*sdl_pkg::SUM_W){1'b0}},
                            sum_im_q, sum_re_q, out_bin_q};

`ifndef SYNTH
  a_spec_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spec_in |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("spectrum transfer did not start the accumulate run");

  a_coef_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !s_axis_tuser_i) |=> (state_q == ST_IDLE))
    else $error("coefficient transfer left the idle state");

  a_block_end_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (bin_q == sdl_pkg::BIN_W'(sdl_pkg::BLOCK_SIZE)))
      |=> (state_q == ST_SWEEP) && m_axis_tvalid_o && m_axis_tlast_o)
    else $error("last bin of a block did not start the spectrum shift");
`endif

endmodule

>>> sim/sdl_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdl_tb_pkg
// stream word layouts and command codes shared by the testbench and checker
// ----------------------------------------------------------------------------
package sdl_tb_pkg;

  import sdl_pkg::*;

  localparam int IN_PAD_W  = IN_TDATA_W - PART_W - BIN_W - 2 * VAL_W;
  localparam int OUT_PAD_W = OUT_TDATA_W - BIN_W - 2 * SUM_W;

  typedef enum logic {
    CMD_LOAD_COEF = 1'b0,
    CMD_SPECTRUM  = 1'b1
  } sdl_cmd_e;

  // first field in the lowest bits
  typedef struct packed {
    logic [IN_PAD_W-1:0]     pad;
    logic signed [VAL_W-1:0] im;
    logic signed [VAL_W-1:0] re;
    logic [BIN_W-1:0]        bin;
    logic [PART_W-1:0]       part;
  } in_word_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]    pad;
    logic signed [SUM_W-1:0] im;
    logic signed [SUM_W-1:0] re;
    logic [BIN_W-1:0]        bin;
  } out_word_t;

endpackage

>>> sim/sdl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdl_checker
// watches both stream channels, keeps its own copy of the delay line and
// coefficient store, predicts each bin sum and compares it field by field
// ----------------------------------------------------------------------------
module sdl_checker
  import sdl_pkg::*;
  import sdl_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   m_tlast_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic [BIN_W-1:0]        bin;
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic                    done;
  } bin_sum_t;

  bin_sum_t sum_q[$];
  cplx_t    ring_mem[PARTITIONS][NBINS];
  cplx_t    coef_mem[PARTITIONS][NBINS];
  int       newest_slot;

  task automatic absorb_item(input sdl_cmd_e cmd, input in_word_t w);
    int       slot;
    int       p;
    longint   a, b, c, d, acc_re, acc_im;
    bin_sum_t r;
    if (w.bin > BLOCK_SIZE) return;
    if (cmd == CMD_LOAD_COEF) begin
      if (w.part < PARTITIONS) begin
        coef_mem[w.part][w.bin].re = w.re;
        coef_mem[w.part][w.bin].im = w.im;
      end
      return;
    end
    ring_mem[newest_slot][w.bin].re = w.re;
    ring_mem[newest_slot][w.bin].im = w.im;
    acc_re = 0;
    acc_im = 0;
    for (p = 0; p < PARTITIONS; p++) begin
      slot = (newest_slot + PARTITIONS - p) % PARTITIONS;
      a = longint'($signed(ring_mem[slot][w.bin].re));
      b = longint'($signed(ring_mem[slot][w.bin].im));
      c = longint'($signed(coef_mem[p][w.bin].re));
      d = longint'($signed(coef_mem[p][w.bin].im));
      acc_re += a * c - b * d;
      acc_im += a * d + b * c;
    end
    r.bin  = w.bin;
    r.re   = acc_re[SUM_W-1:0];
    r.im   = acc_im[SUM_W-1:0];
    r.done = (w.bin == BLOCK_SIZE);
    sum_q.push_back(r);
    // last bin of a block moves the ring on
    if (r.done) newest_slot = (newest_slot + 1) % PARTITIONS;
  endtask

  task automatic check_result(input out_word_t w, input logic last);
    bin_sum_t e;
    if (sum_q.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual bin %0d re %h im %h last %b",
               $time, w.bin, w.re, w.im, last);
      fail_count_o++;
      return;
    end
    e = sum_q.pop_front();
    if (w.bin !== e.bin) begin
      $display("%0t: out_bin expected %0d actual %0d", $time, e.bin, w.bin);
      fail_count_o++;
    end
    if (w.re !== e.re) begin
      $display("%0t: sum_real expected %h actual %h", $time, e.re, w.re);
      fail_count_o++;
    end
    if (w.im !== e.im) begin
      $display("%0t: sum_imag expected %h actual %h", $time, e.im, w.im);
      fail_count_o++;
    end
    if (last !== e.done) begin
      $display("%0t: block_done expected %b actual %b", $time, e.done, last);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ring_mem[i, j]) ring_mem[i][j] = '0;
      foreach (coef_mem[i, j]) coef_mem[i][j] = '0;
      newest_slot  = 0;
      sum_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result(out_word_t'(m_tdata_i), m_tlast_i);
      if (s_tvalid_i && s_tready_i) absorb_item(sdl_cmd_e'(s_tuser_i), in_word_t'(s_tdata_i));
      pending_o = sum_q.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the spectral delay line: directed corner bins, then random
// coefficient columns and spectrum blocks with bursty input and stalled output
// ----------------------------------------------------------------------------
module tb;

  import sdl_pkg::*;
  import sdl_tb_pkg::*;

  localparam int ITEMS = 1400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  int                     fail_count;
  int                     pending;

  bit coef_seen[PARTITIONS][NBINS];
  bit bin_ready[NBINS];
  int ready_bins[$];
  int items_sent;
  int burst_left;

  spectral_delay_line_mac u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  sdl_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input sdl_cmd_e cmd, input logic [PART_W-1:0] part,
                           input logic [BIN_W-1:0] bin, input logic [VAL_W-1:0] re,
                           input logic [VAL_W-1:0] im);
    in_word_t w;
    int       gap;
    w = '{pad: '0, im: im, re: re, bin: bin, part: part};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (bin <= BLOCK_SIZE) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
  endtask

  task automatic load_coef(input int part, input int bin, input logic [VAL_W-1:0] re,
                           input logic [VAL_W-1:0] im);
    bit full;
    send_word(CMD_LOAD_COEF, PART_W'(part), BIN_W'(bin), re, im);
    if (bin > BLOCK_SIZE) return;
    coef_seen[part][bin] = 1'b1;
    full = 1'b1;
    for (int p = 0; p < PARTITIONS; p++) full &= coef_seen[p][bin];
    if (full && !bin_ready[bin]) begin
      bin_ready[bin] = 1'b1;
      ready_bins.push_back(bin);
    end
  endtask

  task automatic send_bin(input int bin, input logic [VAL_W-1:0] re,
                          input logic [VAL_W-1:0] im);
    send_word(CMD_SPECTRUM, PART_W'($urandom), BIN_W'(bin), re, im);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // output side stall pattern, with one long hold-off to back the block up
  initial begin
    int  hi;
    int  lo;
    int  rx_cycles;
    bit  held;
    m_axis_tready = 1'b0;
    rx_cycles = 0;
    held      = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        hi = 200;
        lo = 0;
      end else begin
        hi = $urandom_range(1, 20);
        lo = $urandom_range(1, 8);
      end
      if (!held && rx_cycles > 6000) begin
        lo   = 600;
        held = 1'b1;
      end
      m_axis_tready <= 1'b1;
      repeat (hi) @(negedge clk_i);
      if (lo > 0) begin
        m_axis_tready <= 1'b0;
        repeat (lo) @(negedge clk_i);
      end
      rx_cycles += hi + lo;
    end
  end

  initial begin
    int frame;
    int b;
    int start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    items_sent = 0;
    burst_left = $urandom_range(1, 16);
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner coefficients at the lowest and highest bin
    for (int p = 0; p < PARTITIONS; p++) begin
      if (p % 2 == 0) load_coef(p, 0, {1'b0, {(VAL_W-1){1'b1}}}, {1'b1, {(VAL_W-1){1'b0}}});
      else            load_coef(p, 0, {1'b1, {(VAL_W-1){1'b0}}}, {1'b0, {(VAL_W-1){1'b1}}});
    end
    for (int p = 0; p < PARTITIONS; p++) load_coef(p, BLOCK_SIZE, pick_value(), pick_value());
    // out of range bins are dropped
    load_coef(5, BLOCK_SIZE + 1, pick_value(), pick_value());
    load_coef(2, 127, '1, '1);
    send_bin(127, {1'b0, {(VAL_W-1){1'b1}}}, {1'b0, {(VAL_W-1){1'b1}}});
    send_bin(0, {1'b0, {(VAL_W-1){1'b1}}}, {1'b0, {(VAL_W-1){1'b1}}});
    send_bin(0, {1'b1, {(VAL_W-1){1'b0}}}, {1'b1, {(VAL_W-1){1'b0}}});
    send_bin(BLOCK_SIZE, {1'b1, {(VAL_W-1){1'b0}}}, {1'b0, {(VAL_W-1){1'b1}}});
    send_bin(0, {1'b0, {(VAL_W-1){1'b1}}}, {1'b1, {(VAL_W-1){1'b0}}});

    frame = 0;
    while (items_sent < ITEMS) begin
      frame++;
      if (frame == 35) drain_results();
      if ($urandom_range(0, 1) == 0 && ready_bins.size() < NBINS) begin
        do b = $urandom_range(0, BLOCK_SIZE - 1); while (bin_ready[b]);
        start = $urandom_range(0, PARTITIONS - 1);
        for (int k = 0; k < PARTITIONS; k++)
          load_coef((start + k) % PARTITIONS, b, pick_value(), pick_value());
      end else begin
        repeat ($urandom_range(1, 4))
          load_coef($urandom_range(0, PARTITIONS - 1), $urandom_range(0, BLOCK_SIZE),
                    pick_value(), pick_value());
      end
      if ($urandom_range(0, 5) == 0)
        send_word(sdl_cmd_e'($urandom_range(0, 1)), PART_W'($urandom),
                  BIN_W'($urandom_range(BLOCK_SIZE + 1, 127)), pick_value(), pick_value());
      repeat ($urandom_range(3, 12))
        send_bin(ready_bins[$urandom_range(0, ready_bins.size() - 1)],
                 pick_value(), pick_value());
      if ($urandom_range(0, 7) != 0) send_bin(BLOCK_SIZE, pick_value(), pick_value());
    end

    drain_results();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
